// ===== hdl/serial_frame_receiver_crc16_top_defines.svh =====
// ----------------------------------------------------------------------------
// Serial frame receiver assertion macros
// Concurrent check macros for the frame receiver. They are empty when SYNTH
// is defined.
// ----------------------------------------------------------------------------
`ifndef SERIAL_FRAME_RECEIVER_CRC16_TOP_DEFINES_SVH
`define SERIAL_FRAME_RECEIVER_CRC16_TOP_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SFR_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("frame receiver check failed");
// Next-cycle implication, sampled on the rising clock edge outside reset.
`define SFR_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("frame receiver check failed");
`else
`define SFR_ASSERT_IMP(lbl, ante, cons)
`define SFR_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== hdl/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// Serial frame receiver package
// Shared constants, result codes and the result record of the frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

   // Depth of the frame buffer in bytes.
   localparam int BUFFER_BYTES = 256;
   // Width of the fill count; it must hold BUFFER_BYTES itself.
   localparam int POS_W = $clog2(BUFFER_BYTES + 1);

   localparam logic [15:0] CRC_SEED    = 16'hFFFF;
   localparam logic [15:0] CRC_POLY    = 16'hA001;
   localparam logic [7:0]  SHORT_START = 8'hAA;
   localparam logic [7:0]  LONG_START  = 8'hBB;
   localparam logic [7:0]  END_MARK    = 8'hDD;
   // Fewest buffered bytes for which an end marker is judged as a frame.
   localparam int MIN_FRAME_BYTES = 4;
   // Bytes after the header that are not payload: CRC high, CRC low, trailer.
   localparam int TAIL_BYTES = 3;

   typedef logic [POS_W-1:0] pos_type;

   typedef enum logic [2:0] {
      EV_NONE      = 3'd0,
      EV_GOOD      = 3'd1,
      EV_CRC_ERR   = 3'd2,
      EV_TRAIL_ERR = 3'd3,
      EV_BAD_START = 3'd4,
      EV_TOO_SHORT = 3'd5,
      EV_OVERFLOW  = 3'd6
   } ev_type;

   typedef struct packed {
      logic        payload_valid;
      logic [7:0]  payload_byte;
      logic [7:0]  payload_index;
      ev_type      event_res;
      logic        long_format;
      logic [7:0]  command;
      logic [15:0] payload_length;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hdl/sfr_crc16.sv =====
// ----------------------------------------------------------------------------
// CRC-16 byte update
// Folds one byte into the reflected 0xA001 CRC, one bit per step.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_crc16
   import sfr_pkg::*;
(
   input  wire logic [15:0] crc_cur,
   input  wire logic [7:0]  data,
   output logic      [15:0] crc_next
);

   always_comb begin
      logic [15:0] acc;
      acc = crc_cur ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (acc[0]) begin
            acc = (acc >> 1) ^ CRC_POLY;
         end else begin
            acc = acc >> 1;
         end
      end
      crc_next = acc;
   end

endmodule

`default_nettype wire

// ===== hdl/sfr_frame_tracker.sv =====
// ----------------------------------------------------------------------------
// Frame tracker
// Holds the frame state and judges each received byte combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_frame_tracker
   import sfr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [7:0] rx_byte,
   output rsp_type         result
);

   pos_type     pos_ff,   pos_in;
   logic [7:0]  start_ff, start_in;
   logic [15:0] len_ff,   len_in;
   logic [15:0] crc_ff,   crc_in;
   logic [15:0] rcrc_ff,  rcrc_in;
   logic        end_ff,   end_in;
   logic [7:0]  cmd_ff,   cmd_in;

   logic [15:0] crc_upd;

   sfr_crc16 u_crc (
      .crc_cur  (crc_ff),
      .data     (rx_byte),
      .crc_next (crc_upd)
   );

   always_comb begin
      logic        full;
      logic        good_cur;
      logic [1:0]  hl_cur;
      pos_type     off;
      logic [16:0] off_ext;
      logic [16:0] len_ext;
      logic        good_new;
      logic [1:0]  hl_new;
      logic        clr;

      pos_in   = pos_ff;
      start_in = start_ff;
      len_in   = len_ff;
      crc_in   = crc_ff;
      rcrc_in  = rcrc_ff;
      end_in   = end_ff;
      cmd_in   = cmd_ff;
      result   = '0;
      clr      = 1'b0;

      full     = (pos_ff == pos_type'(BUFFER_BYTES));
      good_cur = (start_ff == SHORT_START) || (start_ff == LONG_START);
      hl_cur   = (start_ff == LONG_START) ? 2'd3 : 2'd2;
      off      = pos_ff - pos_type'(hl_cur);
      off_ext  = 17'(off);
      len_ext  = {1'b0, len_ff};

      if (!full) begin
         pos_in = pos_ff + pos_type'(1);
         if (pos_ff == '0) begin
            start_in = rx_byte;
            len_in   = '0;
            crc_in   = CRC_SEED;
            rcrc_in  = '0;
            end_in   = 1'b0;
            cmd_in   = '0;
         end else if (good_cur) begin
            if (pos_ff < pos_type'(hl_cur)) begin
               // Header: length field, high byte first in the long format.
               if (start_ff == SHORT_START) begin
                  len_in = {8'h00, rx_byte};
               end else if (pos_ff == pos_type'(1)) begin
                  len_in = {rx_byte, 8'h00};
               end else begin
                  len_in = len_ff | {8'h00, rx_byte};
               end
            end else begin
               if (off == '0) begin
                  cmd_in = rx_byte;
               end
               if (off_ext < len_ext) begin
                  crc_in                = crc_upd;
                  result.payload_valid  = 1'b1;
                  result.payload_byte   = rx_byte;
                  result.payload_index  = off_ext[7:0];
               end else if (off_ext == len_ext) begin
                  rcrc_in = {rx_byte, 8'h00};
               end else if (off_ext == len_ext + 17'd1) begin
                  rcrc_in = rcrc_ff | {8'h00, rx_byte};
               end else if (off_ext == len_ext + 17'd2) begin
                  end_in = (rx_byte == END_MARK);
               end
            end
         end
      end

      // Frame description as it stands after this byte.
      good_new = (pos_in != '0) &&
                 ((start_in == SHORT_START) || (start_in == LONG_START));
      hl_new   = (start_in == LONG_START) ? 2'd3 : 2'd2;
      result.long_format    = (pos_in != '0) && (start_in == LONG_START);
      result.command        = (good_new && (pos_in > pos_type'(hl_new))) ? cmd_in : 8'h00;
      result.payload_length = (good_new && (pos_in >= pos_type'(hl_new))) ? len_in : 16'h0000;

      result.event_res = EV_NONE;
      if (full) begin
         result.event_res = EV_OVERFLOW;
         clr              = 1'b1;
      end else if (rx_byte == END_MARK) begin
         if (pos_in < pos_type'(MIN_FRAME_BYTES)) begin
            result.event_res = EV_TOO_SHORT;
            clr              = 1'b1;
         end else if (!good_new) begin
            result.event_res = EV_BAD_START;
            clr              = 1'b1;
         end else if (17'(pos_in) <
                      ({1'b0, len_in} + 17'(hl_new) + 17'(TAIL_BYTES))) begin
            result.event_res = EV_TOO_SHORT;
         end else begin
            if (crc_in != rcrc_in) begin
               result.event_res = EV_CRC_ERR;
            end else if (!end_in) begin
               result.event_res = EV_TRAIL_ERR;
            end else begin
               result.event_res = EV_GOOD;
            end
            clr = 1'b1;
         end
      end

      if (clr) begin
         pos_in  = '0;
         len_in  = '0;
         crc_in  = CRC_SEED;
         rcrc_in = '0;
         end_in  = 1'b0;
         cmd_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         len_ff  <= '0;
         crc_ff  <= CRC_SEED;
         rcrc_ff <= '0;
         end_ff  <= 1'b0;
         cmd_ff  <= '0;
      end else if (step) begin
         pos_ff  <= pos_in;
         len_ff  <= len_in;
         crc_ff  <= crc_in;
         rcrc_ff <= rcrc_in;
         end_ff  <= end_in;
         cmd_ff  <= cmd_in;
      end
   end

   // The start byte is only looked at once the fill count says it was written.
   always_ff @(posedge clock) begin
      if (step) begin
         start_ff <= start_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/serial_frame_receiver_crc16_top.sv =====
// ----------------------------------------------------------------------------
// Serial frame receiver with CRC-16 check
// Deframes a UART byte stream carrying short (0xAA) and long (0xBB) frames.
// ----------------------------------------------------------------------------
// Usage. Each request on the req_ channel carries one received byte on
// req_rx_byte. Every request produces exactly one result on the rsp_ channel,
// in order. A result flags payload bytes with their index, reports the frame
// header as it stands, and on an end marker (0xDD) or a buffer overflow gives
// the verdict on the frame in rsp_event_res.
// Flow: a request accepted into the input register is judged by the frame
// tracker and lands in the result register, which drives rsp_valid, once
// that register can take a new entry. Throughput is one request per clock
// cycle while results are taken or the result register is empty; the limit
// is the combinational byte-wise CRC update and position compare in the
// tracker, which must finish before the next byte of the same frame.
// Reset (synchronous, active high) empties both pipeline registers and
// clears the frame state; the receiver then waits for a start byte.
// Stalls: when rsp_ready is low the result is held stable and the input
// register keeps one further request; req_ready drops only when both are
// occupied and the result is not being taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "serial_frame_receiver_crc16_top_defines.svh"

module serial_frame_receiver_crc16_top
   import sfr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_payload_valid,
   output logic [7:0]       rsp_payload_byte,
   output logic [7:0]       rsp_payload_index,
   output logic [2:0]       rsp_event_res,
   output logic             rsp_long_format,
   output logic [7:0]       rsp_command,
   output logic [15:0]      rsp_payload_length
);

   // Input register: one request waiting to be judged.
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;

   // Result register.
   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   // The result register can take a new entry when it is empty or being read.
   logic    rsp_adv;
   logic    step;
   rsp_type result;

   assign rsp_adv   = !rsp_valid_ff || rsp_ready;
   assign step      = in_valid_ff && rsp_adv;
   assign req_ready = !in_valid_ff || rsp_adv;

   sfr_frame_tracker u_tracker (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (rsp_adv) begin
            rsp_valid_ff <= in_valid_ff;
         end
      end
   end

   // Payload registers carry no reset; the valid flags above qualify them.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
      if (step) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_payload_valid  = rsp_ff.payload_valid;
   assign rsp_payload_byte   = rsp_ff.payload_byte;
   assign rsp_payload_index  = rsp_ff.payload_index;
   assign rsp_event_res      = rsp_ff.event_res;
   assign rsp_long_format    = rsp_ff.long_format;
   assign rsp_command        = rsp_ff.command;
   assign rsp_payload_length = rsp_ff.payload_length;

   // A payload byte can only coincide with no verdict, or with an early end
   // marker that happens to be a payload byte.
   `SFR_ASSERT_IMP(a_payload_event, rsp_valid_ff && rsp_ff.payload_valid, (rsp_ff.event_res == EV_NONE) || (rsp_ff.event_res == EV_TOO_SHORT))

   // A dropped byte is never passed on as payload.
   `SFR_ASSERT_IMP(a_overflow_drop, rsp_valid_ff && (rsp_ff.event_res == EV_OVERFLOW), !rsp_ff.payload_valid)

   // A request waiting behind a full result register is kept intact.
   `SFR_ASSERT_NXT(a_input_hold, in_valid_ff && !rsp_adv, in_valid_ff && $stable(in_byte_ff))

   // Back-pressure only arises when both registers are full and stalled.
   `SFR_ASSERT_IMP(a_ready_cause, !req_ready, in_valid_ff && rsp_valid_ff && !rsp_ready)

endmodule

`default_nettype wire

// ===== dv/tb_serial_frame_receiver_crc16_top.sv =====
// ----------------------------------------------------------------------------
// Serial frame receiver testbench
// Drives received bytes into the frame receiver and checks every result field
// against a cycle-free model of the deframer, under several handshake loads.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_serial_frame_receiver_crc16_top
   import sfr_pkg::*;
();

   localparam int CLOCK_PERIOD    = 10;
   localparam int RESET_CYCLES    = 12;
   // Cycles without any handshake on either channel before the run is abandoned.
   localparam int WATCHDOG_LIMIT  = 2000;
   // Length of the deliberate result hold-off in the first loaded phase.
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int PHASE_REQUESTS  = 280;
   localparam int MAX_PRINTED     = 40;
   localparam int DIRECTED_COUNT  = 27;
   // Header, CRC and trailer bytes of a short frame.
   localparam int SHORT_OVERHEAD  = 5;

   typedef enum int {FLAW_NONE, FLAW_CRC, FLAW_TRAILER, FLAW_TRUNCATE} frame_flaw_type;

   // One row of the directed table. Where typed is set, the result is written
   // out in the row itself; otherwise the frame model supplies it.
   typedef struct {
      logic [7:0] rx_byte;
      bit         typed;
      rsp_type    result;
   } stim_row_type;

   // Results that can be read straight off the frame rules.
   localparam rsp_type R_QUIET       = '0;
   localparam rsp_type R_EARLY_END   = {1'b0, 8'h00, 8'h00, EV_TOO_SHORT, 1'b0, 8'h00, 16'h0000};
   localparam rsp_type R_EMPTY_GOOD  = {1'b0, 8'h00, 8'h00, EV_GOOD, 1'b0, 8'hFF, 16'h0000};
   localparam rsp_type R_BAD_START   = {1'b0, 8'h00, 8'h00, EV_BAD_START, 1'b0, 8'h00, 16'h0000};
   localparam rsp_type R_TRAILER_BAD = {1'b0, 8'h00, 8'h00, EV_TRAIL_ERR, 1'b0, 8'hFF, 16'h0000};

   // Sender gap and receiver stall, in percent, for each load phase.
   localparam int SENDER_GAP [4] = '{0, 52, 0, 14};
   localparam int RX_STALL   [4] = '{0, 0, 52, 14};

   // ------------------------------------------------------------------------
   // Clock, reset and the block's ports. Every input holds a known value from
   // time zero.
   // ------------------------------------------------------------------------
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   logic        rsp_payload_valid;
   logic [7:0]  rsp_payload_byte;
   logic [7:0]  rsp_payload_index;
   logic [2:0]  rsp_event_res;
   logic        rsp_long_format;
   logic [7:0]  rsp_command;
   logic [15:0] rsp_payload_length;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   serial_frame_receiver_crc16_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_payload_valid  (rsp_payload_valid),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_payload_index  (rsp_payload_index),
      .rsp_event_res      (rsp_event_res),
      .rsp_long_format    (rsp_long_format),
      .rsp_command        (rsp_command),
      .rsp_payload_length (rsp_payload_length)
   );

   // ------------------------------------------------------------------------
   // Bookkeeping shared by the sender, the receiver and the checker.
   // ------------------------------------------------------------------------
   rsp_type     expected_results [$];
   int unsigned requests_sent    = 0;
   int unsigned results_checked  = 0;
   int unsigned mismatch_count   = 0;
   int unsigned verdict_count [8];
   int unsigned quiet_cycles     = 0;
   int unsigned sender_gap_pct   = 0;
   int unsigned rx_stall_pct     = 0;
   int unsigned hold_off_left    = 0;

   // ------------------------------------------------------------------------
   // Frame model. It mirrors the deframer's state: the number of bytes held
   // in the frame buffer, the start byte, the length field, the CRC built
   // over the payload so far, the CRC carried by the frame, whether the
   // trailer position held an end marker, and the command byte.
   // ------------------------------------------------------------------------
   int unsigned fill_count   = 0;
   logic [7:0]  frame_start  = 8'h00;
   logic [15:0] length_field = 16'h0000;
   logic [15:0] crc_acc      = CRC_SEED;
   logic [15:0] crc_rx       = 16'h0000;
   bit          trailer_ok   = 1'b0;
   logic [7:0]  cmd_byte     = 8'h00;

   // Reflected CRC-16 update over one byte, least significant bit first.
   function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] data);
      logic [15:0] c;
      c = acc ^ {8'h00, data};
      repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
   endfunction

   // Empties the frame record, leaving keep_count bytes counted as held.
   function automatic void clear_frame(input int unsigned keep_count);
      fill_count   = keep_count;
      length_field = 16'h0000;
      crc_acc      = CRC_SEED;
      crc_rx       = 16'h0000;
      trailer_ok   = 1'b0;
      cmd_byte     = 8'h00;
   endfunction

   // Takes one received byte into the frame model and returns the result the
   // block must give for it. The header fields describe the frame as it stands
   // after the byte, before any clearing that the byte causes.
   function automatic rsp_type predict_result(input logic [7:0] b);
      rsp_type     r;
      int unsigned slot;
      int unsigned hdr;
      int unsigned ofs;
      bit          valid_start;
      bit          dropped;
      r = '0;
      dropped = 1'b0;
      if (fill_count < BUFFER_BYTES) begin
         slot = fill_count;
         fill_count = slot + 1;
         if (slot == 0) begin
            frame_start = b;
            clear_frame(1);
         end else if (frame_start == SHORT_START || frame_start == LONG_START) begin
            hdr = (frame_start == LONG_START) ? 3 : 2;
            if (slot < hdr) begin
               if (frame_start == SHORT_START) length_field = {8'h00, b};
               else if (slot == 1) length_field = {b, 8'h00};
               else length_field[7:0] = b;
            end else begin
               ofs = slot - hdr;
               if (ofs == 0) cmd_byte = b;
               if (ofs < length_field) begin
                  crc_acc = crc16_step(crc_acc, b);
                  r.payload_valid = 1'b1;
                  r.payload_byte  = b;
                  r.payload_index = ofs[7:0];
               end else if (ofs == length_field) begin
                  crc_rx = {b, 8'h00};
               end else if (ofs == length_field + 1) begin
                  crc_rx[7:0] = b;
               end else if (ofs == length_field + 2) begin
                  trailer_ok = (b == END_MARK);
               end
            end
         end
      end else begin
         // Buffer already full: the byte is lost and the frame abandoned.
         dropped = 1'b1;
         r.event_res = EV_OVERFLOW;
      end

      valid_start = fill_count >= 1 && (frame_start == SHORT_START || frame_start == LONG_START);
      hdr = (frame_start == LONG_START) ? 3 : 2;
      r.long_format = fill_count >= 1 && frame_start == LONG_START;
      if (valid_start && fill_count > hdr) r.command = cmd_byte;
      if (valid_start && fill_count >= hdr) r.payload_length = length_field;

      if (dropped) begin
         clear_frame(0);
      end else if (b == END_MARK) begin
         if (fill_count < MIN_FRAME_BYTES) begin
            r.event_res = EV_TOO_SHORT;
            clear_frame(0);
         end else if (!valid_start) begin
            r.event_res = EV_BAD_START;
            clear_frame(0);
         end else if (fill_count < length_field + hdr + TAIL_BYTES) begin
            // The frame is still arriving; the end marker stays in it.
            r.event_res = EV_TOO_SHORT;
         end else begin
            if (crc_acc != crc_rx) r.event_res = EV_CRC_ERR;
            else if (!trailer_ok) r.event_res = EV_TRAIL_ERR;
            else r.event_res = EV_GOOD;
            clear_frame(0);
         end
      end
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Sender side. A request is offered, with random idle cycles in front of
   // it, and held until it is accepted; the expectation is recorded at that
   // same edge, so the frame model is always up to date when the next frame
   // is planned.
   // ------------------------------------------------------------------------
   task automatic offer_byte(input logic [7:0] value, input bit typed, input rsp_type typed_result);
      rsp_type predicted;
      while (sender_gap_pct != 0 && $urandom_range(99) < sender_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      do @(posedge clock); while (!req_ready);
      predicted = predict_result(value);
      if (typed) predicted = typed_result;
      expected_results.push_back(predicted);
      verdict_count[int'(predicted.event_res)]++;
      requests_sent++;
   endtask

   // Sends end markers until the model holds no bytes, so that the next frame
   // starts on a clean buffer.
   task automatic realign();
      while (fill_count != 0) offer_byte(END_MARK, 1'b0, '0);
   endtask

   // Stops offering and waits until every outstanding request has its result.
   task automatic wait_all_results();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // Builds one frame with random payload and a correct CRC, then spoils it
   // as asked: wrong CRC, wrong trailer followed by a late end marker, or a
   // cut somewhere inside the frame followed by an end marker.
   task automatic send_frame(input bit long_fmt, input int unsigned len,
                             input frame_flaw_type flaw);
      logic [7:0]  body [$];
      logic [15:0] crc;
      int unsigned k;
      int unsigned cut;
      realign();
      crc = CRC_SEED;
      body.push_back(long_fmt ? LONG_START : SHORT_START);
      if (long_fmt) body.push_back(len[15:8]);
      body.push_back(len[7:0]);
      for (k = 0; k < len; k++) begin
         body.push_back(8'($urandom_range(255)));
         crc = crc16_step(crc, body[body.size() - 1]);
      end
      if (flaw == FLAW_CRC) crc = crc ^ 16'($urandom_range(16'hFFFF, 1));
      body.push_back(crc[15:8]);
      body.push_back(crc[7:0]);
      if (flaw == FLAW_TRAILER) body.push_back(END_MARK ^ 8'($urandom_range(255, 1)));
      body.push_back(END_MARK);
      if (flaw == FLAW_TRUNCATE) begin
         cut = $urandom_range(body.size() - 2, 1);
         while (body.size() > cut) void'(body.pop_back());
         body.push_back(END_MARK);
      end
      foreach (body[i]) offer_byte(body[i], 1'b0, '0);
   endtask

   // ------------------------------------------------------------------------
   // Receiver side. Ready is redrawn every cycle from the stall rate of the
   // current phase. A hold-off request from the stimulus keeps it low for a
   // long stretch, counted here, so that the block fills and stalls its input.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_off_left != 0) begin
         rsp_ready <= 1'b0;
         hold_off_left--;
      end else begin
         rsp_ready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Checking. Each accepted result is compared field by field with the
   // oldest outstanding expectation.
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      if (mismatch_count < MAX_PRINTED)
         $display("mismatch on result %0d, %s: got %h, expected %h",
                  results_checked, what, got, want);
      mismatch_count++;
   endtask

   task automatic compare_field(input string what, input logic [15:0] got,
                                input logic [15:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result with no request outstanding", 16'h0000, 16'h0000);
         end else begin
            want = expected_results.pop_front();
            compare_field("payload_valid", 16'(rsp_payload_valid),
                          16'(want.payload_valid));
            compare_field("payload_byte", 16'(rsp_payload_byte), 16'(want.payload_byte));
            compare_field("payload_index", 16'(rsp_payload_index),
                          16'(want.payload_index));
            compare_field("event_res", 16'(rsp_event_res), 16'(want.event_res));
            compare_field("long_format", 16'(rsp_long_format), 16'(want.long_format));
            compare_field("command", 16'(rsp_command), 16'(want.command));
            compare_field("payload_length", rsp_payload_length, want.payload_length);
         end
         results_checked++;
      end
   end

   // The watchdog restarts whenever either channel completes a handshake.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("[serial_frame_receiver_crc16_top] ERROR");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Directed table: the early end marker straight after reset, an empty
   // short frame, a long frame carrying one zero byte, an unknown start byte,
   // a trailer that is not an end marker, and an end marker in the middle of
   // a frame that keeps the frame open.
   // ------------------------------------------------------------------------
   stim_row_type directed_rows [DIRECTED_COUNT] = '{
      '{8'hDD, 1'b1, R_EARLY_END},
      '{8'hAA, 1'b1, R_QUIET},
      '{8'h00, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'hDD, 1'b1, R_EMPTY_GOOD},
      '{8'hBB, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h01, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h40, 1'b0, '0},
      '{8'hBF, 1'b0, '0},
      '{8'hDD, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'hDD, 1'b1, R_BAD_START},
      '{8'hAA, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'hDD, 1'b1, R_TRAILER_BAD},
      '{8'hAA, 1'b0, '0},
      '{8'h03, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'hDD, 1'b0, '0}
   };

   // ------------------------------------------------------------------------
   // Stimulus. After the directed table come four load phases of random
   // traffic: mostly well-formed frames with random content and small
   // lengths, the rest corrupted or cut frames, line noise and early end
   // markers. The first phase also holds off the results for a long stretch;
   // the second fills the buffer past its end with an end marker as the lost
   // byte; the last sends a frame that fits the buffer exactly. Between
   // phases the sender waits until every result has come back.
   // ------------------------------------------------------------------------
   initial begin
      int unsigned    phase_goal;
      int unsigned    pick;
      int unsigned    roll;
      int unsigned    len;
      frame_flaw_type flaw;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         offer_byte(directed_rows[i].rx_byte, directed_rows[i].typed, directed_rows[i].result);
      wait_all_results();

      for (int phase = 0; phase < 4; phase++) begin
         sender_gap_pct = SENDER_GAP[phase];
         rx_stall_pct   = RX_STALL[phase];
         phase_goal     = requests_sent + PHASE_REQUESTS;
         if (phase == 0) hold_off_left = HOLD_OFF_CYCLES;
         if (phase == 1) begin
            // A long frame whose length cannot fit: the buffer fills up and
            // the next byte, an end marker here, is dropped.
            realign();
            offer_byte(LONG_START, 1'b0, '0);
            offer_byte(8'h01, 1'b0, '0);
            offer_byte(8'h00, 1'b0, '0);
            while (fill_count < BUFFER_BYTES) offer_byte(8'($urandom_range(255)), 1'b0, '0);
            offer_byte(END_MARK, 1'b0, '0);
         end
         if (phase == 3) send_frame(1'b0, BUFFER_BYTES - SHORT_OVERHEAD, FLAW_NONE);

         while (requests_sent < phase_goal) begin
            pick = $urandom_range(99);
            len  = ($urandom_range(99) < 6) ? $urandom_range(120, 13) : $urandom_range(12, 0);
            if (pick < 81) begin
               if (pick < 55) flaw = FLAW_NONE;
               else if (pick < 65) flaw = FLAW_CRC;
               else if (pick < 73) flaw = FLAW_TRAILER;
               else flaw = FLAW_TRUNCATE;
               send_frame(1'($urandom_range(1)), len, flaw);
            end else if (pick < 95) begin
               // Line noise, rich in start bytes and end markers.
               repeat ($urandom_range(8, 1)) begin
                  roll = $urandom_range(99);
                  if (roll < 10) offer_byte(SHORT_START, 1'b0, '0);
                  else if (roll < 20) offer_byte(LONG_START, 1'b0, '0);
                  else if (roll < 35) offer_byte(END_MARK, 1'b0, '0);
                  else offer_byte(8'($urandom_range(255)), 1'b0, '0);
               end
            end else begin
               // End marker with fewer than four bytes held.
               realign();
               repeat ($urandom_range(2, 0))
                  offer_byte(END_MARK ^ 8'($urandom_range(255, 1)), 1'b0, '0);
               offer_byte(END_MARK, 1'b0, '0);
            end
         end
         wait_all_results();
      end

      // Let any stray result surface before the verdict.
      repeat (8) @(posedge clock);
      if (expected_results.size() != 0)
         report_mismatch("results never delivered", 16'(expected_results.size()), 16'h0000);

      $display("Run covered %0d requests (%0d from the directed table) over four load phases.",
               requests_sent, DIRECTED_COUNT);
      $display("Verdicts: %0d good, %0d bad CRC, %0d bad trailer, %0d bad start, %0d short, %0d lost",
               verdict_count[EV_GOOD], verdict_count[EV_CRC_ERR], verdict_count[EV_TRAIL_ERR],
               verdict_count[EV_BAD_START], verdict_count[EV_TOO_SHORT],
               verdict_count[EV_OVERFLOW]);
      if (mismatch_count == 0) begin
         $display("[serial_frame_receiver_crc16_top] OK");
      end else begin
         $display("[serial_frame_receiver_crc16_top] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
